>>> hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
`default_nettype none
package i2cm_pkg;

	// Command / item kinds
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_STOP  = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_WACK  = 3'd4;
	localparam logic [2:0] KIND_READ  = 3'd5;
	localparam logic [2:0] CMD_IDLE   = 3'd0;

	// Sequence phases
	localparam logic [3:0] PH0         = 4'd0;
	localparam logic [3:0] PH1         = 4'd1;
	localparam logic [3:0] PH2         = 4'd2;
	localparam logic [3:0] PH3         = 4'd3;
	localparam logic [3:0] PH4         = 4'd4;
	localparam logic [3:0] PH_FIN_MISS = 4'd14;
	localparam logic [3:0] PH_FIN      = 4'd15;

	// Configuration register indexes
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_DELAY_EN    = 2'd1;
	localparam logic [1:0] REG_TICKS_UNIT  = 2'd2;

	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd200;
	localparam logic [7:0]  TICKS_UNIT_RST  = 8'd8;

	// Delay shift amounts: 1, 2 and 4 units
	localparam logic [1:0] DLY_1U = 2'd0;
	localparam logic [1:0] DLY_2U = 2'd1;
	localparam logic [1:0] DLY_4U = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// 4 units * 255 ticks = 1020 fits in 10 bits
	localparam int DLY_W = 10;

	typedef struct packed {
		logic [15:0] ack_timeout;
		logic        delay_en;
		logic [7:0]  ticks_unit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [3:0]       phase;
		logic [3:0]       bit_idx;
		logic [7:0]       shreg;
		logic [DLY_W-1:0] delay;
		logic [15:0]      timeout;
		logic             ack_choice;
		logic             scl;
		logic             sda;
		logic             sda_oe;
	} state_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_oe;
		logic       busy;
		logic       done;
		logic [7:0] rbyte;
		logic       miss;
		logic       rej;
	} res_t;

endpackage
`default_nettype wire

>>> hw/rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: item register, step logic, result register.
//
//  channel   direction  handshake            payload
//  cmd       in         cmd_valid/cmd_stall  kind, write_byte, ack_after_read, sda_in
//  res       out        res_valid/res_stall  scl, sda_out, sda_drive_enable, busy_res,
//                                            done_res, read_byte, ack_missing, cmd_rejected
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item passes from the item register (s1) through the step logic into the result
// register. A new item can enter every cycle while cmd_stall is low; throughput is one
// item per cycle while res does not stall. arst_n clears control state (not the result
// register), sets the engine pin state idle (SCL/SDA high, driving) and loads the register
// defaults. A stall on res holds the result register and, once s1 is full, stalls cmd; an
// empty s1 still takes one more item while a result waits.
`default_nettype none
module i2c_master_byte_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command / tick channel
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  write_byte,
	input  wire logic        ack_after_read,
	input  wire logic        sda_in,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             scl,
	output logic             sda_out,
	output logic             sda_drive_enable,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       read_byte,
	output logic             ack_missing,
	output logic             cmd_rejected,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import i2cm_pkg::*;

	cfg_t   cfg;
	state_t st_q, st_nxt;
	res_t   res_nxt, res_q;

	logic       v_s1;
	logic [2:0] kind_s1;
	logic [7:0] wbyte_s1;
	logic       ack_s1;
	logic       sda_s1;
	logic       res_v_q;
	logic       advance;   // s1 item moves into the result register
	logic       take;      // cmd transfer this cycle

	// Registers are always writable; writes must happen only while idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	i2cm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance   = v_s1 && (!res_v_q || !res_stall);
	assign cmd_stall = v_s1 && !advance;
	assign take      = cmd_valid && !cmd_stall;

	// Item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= kind;
			wbyte_s1 <= write_byte;
			ack_s1   <= ack_after_read;
			sda_s1   <= sda_in;
		end
	end

	i2cm_step u_step (
		.cfg            (cfg),
		.st             (st_q),
		.kind           (kind_s1),
		.write_byte     (wbyte_s1),
		.ack_after_read (ack_s1),
		.sda_in         (sda_s1),
		.nxt            (st_nxt),
		.res            (res_nxt)
	);

	// Engine state: updated once per item, when its result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{cmd: CMD_IDLE, phase: PH0, bit_idx: '0, shreg: '0, delay: '0,
				timeout: '0, ack_choice: 1'b0, scl: 1'b1, sda: 1'b1, sda_oe: 1'b1};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (advance) begin
			res_v_q <= 1'b1;
		end else if (!res_stall) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid        = res_v_q;
	assign scl              = res_q.scl;
	assign sda_out          = res_q.sda_out;
	assign sda_drive_enable = res_q.sda_oe;
	assign busy_res         = res_q.busy;
	assign done_res         = res_q.done;
	assign read_byte        = res_q.rbyte;
	assign ack_missing      = res_q.miss;
	assign cmd_rejected     = res_q.rej;

endmodule
`default_nettype wire

>>> hw/rtl/i2cm_cfg_regs.sv
// Configuration register file of the I2C master byte engine.
`default_nettype none
module i2cm_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [1:0]    wr_index,
	input  wire logic [15:0]   wr_data,
	output i2cm_pkg::cfg_t     cfg
);
	import i2cm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ack_timeout: ACK_TIMEOUT_RST, delay_en: 1'b1,
				ticks_unit: TICKS_UNIT_RST};
		end else if (wr_en) begin
			case (wr_index)
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= wr_data;
				REG_DELAY_EN:    cfg_q.delay_en    <= wr_data[0];
				REG_TICKS_UNIT:  cfg_q.ticks_unit  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> hw/rtl/i2cm_step.sv
// Next-state and result logic for one item of the I2C master byte engine.
`default_nettype none
module i2cm_step (
	input  wire i2cm_pkg::cfg_t   cfg,
	input  wire i2cm_pkg::state_t st,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  write_byte,
	input  wire logic        ack_after_read,
	input  wire logic        sda_in,
	output i2cm_pkg::state_t nxt,
	output i2cm_pkg::res_t   res
);
	import i2cm_pkg::*;

	function automatic logic [DLY_W-1:0] arm(input logic en, input logic [7:0] tpu,
			input logic [1:0] sh);
		logic [DLY_W-1:0] base;
		base = {{(DLY_W-8){1'b0}}, tpu};
		return en ? (base << sh) : '0;
	endfunction

	logic [3:0] bit_nxt;
	state_t     n;
	logic       fin;

	assign bit_nxt = st.bit_idx + 4'd1;

	always_comb begin
		n   = st;
		res = '0;
		fin = 1'b0;
		if (kind inside {[KIND_START:KIND_READ]}) begin
			if (st.cmd != CMD_IDLE) begin
				res.rej = 1'b1;
			end else begin
				n.cmd     = kind;
				n.phase   = PH0;
				n.bit_idx = '0;
				n.delay   = '0;
				n.timeout = '0;
				n.shreg   = (kind == KIND_WRITE) ? write_byte : 8'h00;
				if (kind == KIND_READ) n.ack_choice = ack_after_read;
			end
		end else if (kind == KIND_TICK && st.cmd != CMD_IDLE) begin
			if (st.delay != '0) begin
				n.delay = st.delay - DLY_W'(1);
			end else if (st.phase != PH_FIN && st.phase != PH_FIN_MISS) begin
				case (st.cmd)
					KIND_START: begin
						if (st.phase == PH0) begin
							n.sda_oe = 1'b1; n.sda = 1'b1; n.scl = 1'b1;
							n.delay  = arm(cfg.delay_en, cfg.ticks_unit, DLY_4U);
							n.phase  = PH1;
						end else if (st.phase == PH1) begin
							n.sda   = 1'b0;
							n.delay = arm(cfg.delay_en, cfg.ticks_unit, DLY_4U);
							n.phase = PH2;
						end else begin
							n.scl = 1'b0; n.phase = PH_FIN;
						end
					end
					KIND_STOP: begin
						if (st.phase == PH0) begin
							n.sda_oe = 1'b1; n.scl = 1'b0; n.sda = 1'b0;
							n.delay  = arm(cfg.delay_en, cfg.ticks_unit, DLY_4U);
							n.phase  = PH1;
						end else begin
							n.scl = 1'b1; n.sda = 1'b1;
							n.delay = arm(cfg.delay_en, cfg.ticks_unit, DLY_4U);
							n.phase = PH_FIN;
						end
					end
					KIND_WRITE: begin
						if (st.phase == PH0) begin
							n.sda_oe = 1'b1; n.sda = st.shreg[7];
							n.shreg  = {st.shreg[6:0], 1'b0};
							n.delay  = arm(cfg.delay_en, cfg.ticks_unit, DLY_2U);
							n.phase  = PH1;
						end else if (st.phase == PH1) begin
							n.scl   = 1'b1;
							n.delay = arm(cfg.delay_en, cfg.ticks_unit, DLY_2U);
							n.phase = PH2;
						end else begin
							n.scl     = 1'b0;
							n.delay   = arm(cfg.delay_en, cfg.ticks_unit, DLY_2U);
							n.bit_idx = bit_nxt;
							n.phase   = (bit_nxt >= BITS_PER_BYTE) ? PH_FIN : PH0;
						end
					end
					KIND_WACK: begin
						if (st.phase == PH0) begin
							n.sda_oe = 1'b0;
							n.delay  = arm(cfg.delay_en, cfg.ticks_unit, DLY_1U);
							n.phase  = PH1;
						end else if (st.phase == PH1) begin
							n.scl     = 1'b1;
							n.delay   = arm(cfg.delay_en, cfg.ticks_unit, DLY_1U);
							n.timeout = cfg.ack_timeout;
							n.phase   = PH2;
						end else if (st.phase == PH2) begin
							if (!sda_in) begin
								n.scl = 1'b0; n.phase = PH_FIN;
							end else if (st.timeout == '0) begin
								// no ACK: start the stop sequence in this step
								n.sda_oe = 1'b1; n.scl = 1'b0; n.sda = 1'b0;
								n.delay  = arm(cfg.delay_en, cfg.ticks_unit, DLY_4U);
								n.phase  = PH3;
							end else begin
								n.timeout = st.timeout - 16'd1;
							end
						end else begin
							n.scl = 1'b1; n.sda = 1'b1;
							n.delay = arm(cfg.delay_en, cfg.ticks_unit, DLY_4U);
							n.phase = PH_FIN_MISS;
						end
					end
					KIND_READ: begin
						if (st.phase == PH0) begin
							n.sda_oe = 1'b0; n.scl = 1'b0;
							n.delay  = arm(cfg.delay_en, cfg.ticks_unit, DLY_2U);
							n.phase  = PH1;
						end else if (st.phase == PH1) begin
							n.scl     = 1'b1;
							n.shreg   = {st.shreg[6:0], sda_in};
							n.delay   = arm(cfg.delay_en, cfg.ticks_unit, DLY_1U);
							n.bit_idx = bit_nxt;
							n.phase   = (bit_nxt >= BITS_PER_BYTE) ? PH2 : PH0;
						end else if (st.phase == PH2) begin
							n.scl = 1'b0; n.sda_oe = 1'b1; n.sda = ~st.ack_choice;
							n.delay = arm(cfg.delay_en, cfg.ticks_unit, DLY_2U);
							n.phase = PH3;
						end else if (st.phase == PH3) begin
							n.scl   = 1'b1;
							n.delay = arm(cfg.delay_en, cfg.ticks_unit, DLY_2U);
							n.phase = PH4;
						end else begin
							n.scl = 1'b0; n.phase = PH_FIN;
						end
					end
					default: n.phase = PH_FIN;
				endcase
			end
			fin = (n.delay == '0) && (n.phase == PH_FIN || n.phase == PH_FIN_MISS);
			if (fin) begin
				res.done  = 1'b1;
				res.rbyte = (st.cmd == KIND_READ) ? n.shreg : 8'h00;
				res.miss  = (n.phase == PH_FIN_MISS);
				n.cmd     = CMD_IDLE;
				n.phase   = PH0;
				n.bit_idx = '0;
			end
		end
		res.scl     = n.scl;
		res.sda_out = n.sda;
		res.sda_oe  = n.sda_oe;
		res.busy    = (n.cmd != CMD_IDLE);
	end

	assign nxt = n;

endmodule
`default_nettype wire

>>> hw/rtl/i2cm_checker.sv
// Port-level checker for the I2C master byte engine, with its bind.
`default_nettype none
module i2cm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic       scl,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [7:0] read_byte,
	input wire logic       ack_missing,
	input wire logic       cmd_rejected
);

	// A finished command leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done with busy still set");

	// Rejection only happens while a command is running, which keeps running
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && cmd_rejected |-> busy_res && !done_res)
		else $error("rejected command while idle");

	// Missing ACK and read data only come with the done pulse
	a_flags_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (ack_missing || read_byte != 8'h00) |-> done_res)
		else $error("status without done");

	// Missing ACK ends with the stop sequence, SCL released high
	a_miss_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ack_missing |-> scl)
		else $error("ack timeout without stop");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(done_res) && $stable(read_byte))
		else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.scl          (scl),
	.busy_res     (busy_res),
	.done_res     (done_res),
	.read_byte    (read_byte),
	.ack_missing  (ack_missing),
	.cmd_rejected (cmd_rejected)
);
`default_nettype wire

>>> sim/i2c_master_byte_engine_tb.sv
// Self-checking testbench for the I2C master byte engine: pin sequences predicted per item.
`timescale 1ns / 1ps
module i2c_master_byte_engine_tb;
	import i2cm_pkg::*;

	// Kinds above READ carry no command; the engine drops them like an idle tick
	localparam logic [2:0] KIND_NOP6 = 3'd6;
	localparam logic [2:0] KIND_NOP7 = 3'd7;
	localparam int RUN_LIMIT_NS = 5_000_000;

	// Tracks the engine state item by item and queues the pin levels each item must give.
	class bus_pin_tracker;
		cfg_t        regs;
		logic [2:0]  cmd;
		logic [3:0]  phase;
		logic [3:0]  bit_idx;
		logic [7:0]  shreg;
		logic [15:0] delay_left;
		logic [16:0] poll_left;
		logic        ack_sel;
		logic        scl_lv;
		logic        sda_lv;
		logic        sda_oe;
		res_t        due_pins[$];
		int          errors;

		function new();
			regs = '{ack_timeout: ACK_TIMEOUT_RST, delay_en: 1'b1, ticks_unit: TICKS_UNIT_RST};
			cmd = CMD_IDLE;
			phase = PH0;
			bit_idx = '0;
			shreg = '0;
			delay_left = '0;
			poll_left = '0;
			ack_sel = 1'b0;
			scl_lv = 1'b1;
			sda_lv = 1'b1;
			sda_oe = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_ACK_TIMEOUT: regs.ack_timeout = val;
				REG_DELAY_EN:    regs.delay_en = val[0];
				REG_TICKS_UNIT:  regs.ticks_unit = val[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_pins.size();
		endfunction

		// Delays are 1, 2 or 4 units, given as a shift of ticks_unit
		function void arm(logic [1:0] sh);
			delay_left = regs.delay_en ? (16'(regs.ticks_unit) << sh) : 16'd0;
		endfunction

		// First half of a STOP: pull both lines low
		function void stop_lead();
			sda_oe = 1'b1;
			scl_lv = 1'b0;
			sda_lv = 1'b0;
			arm(DLY_4U);
		endfunction

		function void pin_step(logic sd);
			case (cmd)
				KIND_START: begin
					if (phase == PH0) begin
						sda_oe = 1'b1; sda_lv = 1'b1; scl_lv = 1'b1; arm(DLY_4U); phase = PH1;
					end else if (phase == PH1) begin
						sda_lv = 1'b0; arm(DLY_4U); phase = PH2;
					end else begin
						scl_lv = 1'b0; phase = PH_FIN;
					end
				end
				KIND_STOP: begin
					if (phase == PH0) begin
						stop_lead(); phase = PH1;
					end else begin
						scl_lv = 1'b1; sda_lv = 1'b1; arm(DLY_4U); phase = PH_FIN;
					end
				end
				KIND_WRITE: begin
					if (phase == PH0) begin
						sda_oe = 1'b1; sda_lv = shreg[7]; shreg = {shreg[6:0], 1'b0};
						arm(DLY_2U); phase = PH1;
					end else if (phase == PH1) begin
						scl_lv = 1'b1; arm(DLY_2U); phase = PH2;
					end else begin
						scl_lv = 1'b0; arm(DLY_2U); bit_idx = bit_idx + 4'd1;
						phase = (bit_idx >= BITS_PER_BYTE) ? PH_FIN : PH0;
					end
				end
				KIND_WACK: begin
					if (phase == PH0) begin
						sda_oe = 1'b0; arm(DLY_1U); phase = PH1;
					end else if (phase == PH1) begin
						scl_lv = 1'b1; arm(DLY_1U); poll_left = 17'(regs.ack_timeout);
						phase = PH2;
					end else if (phase == PH2) begin
						if (!sd) begin
							scl_lv = 1'b0; phase = PH_FIN;
						end else if (poll_left == 0) begin
							stop_lead(); phase = PH3;
						end else begin
							poll_left = poll_left - 17'd1;
						end
					end else begin
						scl_lv = 1'b1; sda_lv = 1'b1; arm(DLY_4U); phase = PH_FIN_MISS;
					end
				end
				KIND_READ: begin
					if (phase == PH0) begin
						sda_oe = 1'b0; scl_lv = 1'b0; arm(DLY_2U); phase = PH1;
					end else if (phase == PH1) begin
						scl_lv = 1'b1; shreg = {shreg[6:0], sd}; arm(DLY_1U);
						bit_idx = bit_idx + 4'd1;
						phase = (bit_idx >= BITS_PER_BYTE) ? PH2 : PH0;
					end else if (phase == PH2) begin
						scl_lv = 1'b0; sda_oe = 1'b1; sda_lv = !ack_sel; arm(DLY_2U); phase = PH3;
					end else if (phase == PH3) begin
						scl_lv = 1'b1; arm(DLY_2U); phase = PH4;
					end else begin
						scl_lv = 1'b0; phase = PH_FIN;
					end
				end
				default: phase = PH_FIN;
			endcase
		endfunction

		function void note_item(logic [2:0] k, logic [7:0] wb, logic ar, logic sd);
			res_t r;
			r = '0;
			if (k >= KIND_START && k <= KIND_READ) begin
				if (cmd != CMD_IDLE) begin
					r.rej = 1'b1;
				end else begin
					cmd = k; phase = PH0; bit_idx = '0; delay_left = '0; poll_left = '0;
					shreg = (k == KIND_WRITE) ? wb : 8'h00;
					if (k == KIND_READ)
						ack_sel = ar;
				end
			end else if (k == KIND_TICK && cmd != CMD_IDLE) begin
				if (delay_left != 0)
					delay_left = delay_left - 16'd1;
				else if (phase != PH_FIN && phase != PH_FIN_MISS)
					pin_step(sd);
				if (delay_left == 0 && (phase == PH_FIN || phase == PH_FIN_MISS)) begin
					r.done = 1'b1;
					if (cmd == KIND_READ)
						r.rbyte = shreg;
					r.miss = (phase == PH_FIN_MISS);
					cmd = CMD_IDLE; phase = PH0; bit_idx = '0;
				end
			end
			r.scl = scl_lv;
			r.sda_out = sda_lv;
			r.sda_oe = sda_oe;
			r.busy = (cmd != CMD_IDLE);
			due_pins.push_back(r);
		endfunction

		function void cmp(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_pins(res_t got);
			res_t want;
			if (due_pins.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %0h", $time, got);
				return;
			end
			want = due_pins.pop_front();
			cmp("scl", 8'(want.scl), 8'(got.scl));
			cmp("sda_out", 8'(want.sda_out), 8'(got.sda_out));
			cmp("sda_drive_enable", 8'(want.sda_oe), 8'(got.sda_oe));
			cmp("busy_res", 8'(want.busy), 8'(got.busy));
			cmp("done_res", 8'(want.done), 8'(got.done));
			cmp("read_byte", want.rbyte, got.rbyte);
			cmp("ack_missing", 8'(want.miss), 8'(got.miss));
			cmp("cmd_rejected", 8'(want.rej), 8'(got.rej));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [2:0]  kind = KIND_TICK;
	logic [7:0]  write_byte = 8'h00;
	logic        ack_after_read = 1'b0;
	logic        sda_in = 1'b1;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        scl;
	logic        sda_out;
	logic        sda_drive_enable;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_byte;
	logic        ack_missing;
	logic        cmd_rejected;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_ACK_TIMEOUT;
	logic [15:0] cfg_data = 16'h0000;

	bus_pin_tracker pins = new();
	int burst_left = 0;

	i2c_master_byte_engine i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.kind             (kind),
		.write_byte       (write_byte),
		.ack_after_read   (ack_after_read),
		.sda_in           (sda_in),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.scl              (scl),
		.sda_out          (sda_out),
		.sda_drive_enable (sda_drive_enable),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.read_byte        (read_byte),
		.ack_missing      (ack_missing),
		.cmd_rejected     (cmd_rejected),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result monitor: a transfer happens on a rising edge with valid high and stall low.
	// Reading in the active region sees the levels from before the edge.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			pins.check_pins({scl, sda_out, sda_drive_enable, busy_res, done_res,
				read_byte, ack_missing, cmd_rejected});
	end

	// Receiver back-pressure: switches between free flow, light and heavy stalling
	// in stretches of random length, always updated on the falling edge.
	initial begin
		int stall_mode;
		int span;
		@(posedge arst_n);
		forever begin
			stall_mode = $urandom_range(0, 2);
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(negedge clk);
				case (stall_mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					default: res_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// One item transfer. Called at a falling edge, returns at a falling edge with valid
	// still high, so the caller either presents the next item or lowers valid there.
	// The sender runs in bursts; a new burst often starts after a short gap.
	task automatic xfer_item(logic [2:0] k, logic [7:0] wb, logic ar, logic sd);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		cmd_valid <= 1'b1;
		kind <= k;
		write_byte <= wb;
		ack_after_read <= ar;
		sda_in <= sd;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pins.note_item(k, wb, ar, sd);
		burst_left--;
		@(negedge clk);
	endtask

	// Keep ticking with a fixed SDA level until the running command is done
	task automatic tick_to_idle(logic sd);
		while (pins.cmd != CMD_IDLE)
			xfer_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sd);
	endtask

	// Sender lowers valid and holds off until every expected result is in
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (pins.pending() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pins.set_reg(idx, val);
		@(negedge clk);
	endtask

	// Finish any command, let the pipe empty, then rewrite all three registers
	task automatic reconfigure(logic [15:0] timeout, logic den, logic [7:0] tpu);
		tick_to_idle(1'b0);
		drain_results();
		write_reg(REG_ACK_TIMEOUT, timeout);
		write_reg(REG_DELAY_EN, {15'd0, den});
		write_reg(REG_TICKS_UNIT, {8'd0, tpu});
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed traffic: a command when idle, then ticks until done, with a
	// sprinkle of commands that hit a busy engine and of no-op kinds. While waiting for
	// an ACK, SDA leans high so that short timeouts actually expire.
	task automatic random_item();
		logic [2:0] k;
		logic [7:0] wb;
		logic       ar;
		logic       sd;
		int         roll;
		wb = 8'($urandom_range(0, 255));
		ar = 1'($urandom_range(0, 1));
		sd = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (pins.cmd == CMD_IDLE) begin
			if (roll < 75)
				k = 3'($urandom_range(KIND_START, KIND_READ));
			else if (roll < 90)
				k = KIND_TICK;
			else
				k = roll[0] ? KIND_NOP6 : KIND_NOP7;
		end else begin
			if (roll < 92)
				k = KIND_TICK;
			else if (roll < 97)
				k = 3'($urandom_range(KIND_START, KIND_READ));
			else
				k = roll[0] ? KIND_NOP6 : KIND_NOP7;
			if (pins.cmd == KIND_WACK && pins.phase == PH2)
				sd = ($urandom_range(0, 2) != 0);
		end
		xfer_item(k, wb, ar, sd);
	endtask

	task automatic random_run(int n);
		repeat (n) begin
			random_item();
			if ($urandom_range(0, 199) == 0)
				drain_results();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Register defaults: ticks and no-op kinds on an idle engine, then a START
		// with other commands thrown at it while it runs
		xfer_item(KIND_TICK, 8'h00, 1'b0, 1'b1);
		xfer_item(KIND_NOP6, 8'hFF, 1'b1, 1'b0);
		xfer_item(KIND_NOP7, 8'h00, 1'b0, 1'b1);
		xfer_item(KIND_START, 8'h00, 1'b0, 1'b1);
		xfer_item(KIND_TICK, 8'h00, 1'b0, 1'b1);
		xfer_item(KIND_STOP, 8'h00, 1'b0, 1'b1);
		xfer_item(KIND_READ, 8'hFF, 1'b1, 1'b1);
		xfer_item(KIND_NOP7, 8'h00, 1'b0, 1'b1);
		tick_to_idle(1'b1);

		// No delays (ticks_per_unit at its top is then ignored), ACK timeout of zero:
		// write extremes, ACK missing and present, read all ones with ACK and
		// all zeros with NACK
		reconfigure(16'd0, 1'b0, 8'd255);
		xfer_item(KIND_WRITE, 8'hFF, 1'b0, 1'b0);
		tick_to_idle(1'b1);
		xfer_item(KIND_WRITE, 8'h00, 1'b1, 1'b1);
		tick_to_idle(1'b0);
		xfer_item(KIND_WACK, 8'h00, 1'b0, 1'b1);
		tick_to_idle(1'b1);
		xfer_item(KIND_WACK, 8'h00, 1'b0, 1'b0);
		tick_to_idle(1'b0);
		xfer_item(KIND_READ, 8'h00, 1'b1, 1'b1);
		tick_to_idle(1'b1);
		xfer_item(KIND_READ, 8'h00, 1'b0, 1'b0);
		tick_to_idle(1'b0);
		xfer_item(KIND_STOP, 8'h00, 1'b0, 1'b0);
		tick_to_idle(1'b0);

		// Slower bus and longest timeout: one STOP with full 4-unit delays
		reconfigure(16'hFFFF, 1'b1, 8'd16);
		xfer_item(KIND_STOP, 8'h00, 1'b0, 1'b1);
		tick_to_idle(1'b1);

		// Delays on but zero ticks per unit; ACK given up after a few high polls
		reconfigure(16'd3, 1'b1, 8'd0);
		xfer_item(KIND_START, 8'h00, 1'b0, 1'b1);
		tick_to_idle(1'b1);
		xfer_item(KIND_WACK, 8'h00, 1'b0, 1'b1);
		tick_to_idle(1'b1);

		// Random traffic over a few bus speeds and timeouts
		reconfigure(16'($urandom_range(0, 4)), 1'b0, 8'($urandom_range(1, 255)));
		random_run(80);
		reconfigure(16'd0, 1'b1, 8'd1);
		random_run(80);
		reconfigure(16'($urandom_range(2, 6)), 1'b1, 8'd2);
		random_run(60);

		tick_to_idle(1'b0);
		drain_results();
		repeat (5) @(posedge clk);
		if (pins.errors == 0 && pins.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: a hung handshake ends the run here
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> i2c_master_byte_engine.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_cfg_regs.sv
hw/rtl/i2cm_step.sv
hw/rtl/i2c_master_byte_engine.sv
hw/rtl/i2cm_checker.sv
sim/i2c_master_byte_engine_tb.sv
